// ===== hw/rtl/shabh_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 byte hasher.
// Used by shabh_ctrl, shabh_dp and sha256_byte_hasher; depends on nothing.

package shabh_pkg;

    localparam int WordW  = 32;
    localparam int Words  = 8;
    localparam int Rounds = 64;

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;
    localparam logic [5:0] LastPos = 6'd63;

    localparam logic [WordW-1:0] InitHash [Words] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Source of the byte that enters the message block.
    typedef enum logic [1:0] {
        SEL_DATA  = 2'd0,
        SEL_PAD80 = 2'd1,
        SEL_ZERO  = 2'd2,
        SEL_LEN   = 2'd3
    } byte_sel_t;

    typedef struct packed {
        logic       shift_en;
        byte_sel_t  byte_sel;
        logic       latch_len;
        logic       load_work;
        logic       round_en;
        logic [5:0] round_idx;
        logic       final_add;
        logic       out_load;
        logic [2:0] out_idx;
        logic       clear_msg;
    } shabh_cmd_t;

    typedef struct packed {
        logic [5:0] pos;
        logic       out_free;
    } shabh_stat_t;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== hw/rtl/shabh_ctrl.sv =====
// Sequencer for the SHA-256 byte hasher: absorb, padding, rounds, digest output.
// Depends on shabh_pkg; drives shabh_dp through a command struct.

module shabh_ctrl
    import shabh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic        in_kind,
    output logic        in_ready,
    input  shabh_stat_t stat,
    output shabh_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FINAL = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] round_reg, round_next;
    logic [2:0] emit_reg, emit_next;
    logic       fin_reg, fin_next;
    logic       len_ok_reg, len_ok_next;
    logic       done_reg, done_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        round_next  = round_reg;
        emit_next   = emit_reg;
        fin_next    = fin_reg;
        len_ok_next = len_ok_reg;
        done_next   = done_reg;
        cmd         = '0;
        cmd.byte_sel  = SEL_DATA;
        cmd.round_idx = round_reg;
        cmd.out_idx   = emit_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.shift_en = 1'b1;
                    if (in_kind) begin
                        cmd.byte_sel  = SEL_PAD80;
                        cmd.latch_len = 1'b1;
                        fin_next      = 1'b1;
                        // The length fits in this block when the marker lands early enough.
                        if (stat.pos < LenPos) begin
                            len_ok_next = 1'b1;
                        end
                    end
                    if (stat.pos == LastPos) begin
                        cmd.load_work = 1'b1;
                        round_next    = '0;
                        state_next    = ST_ROUND;
                    end else if (in_kind) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.shift_en = 1'b1;
                if (stat.pos < LenPos) begin
                    cmd.byte_sel = SEL_ZERO;
                    len_ok_next  = 1'b1;
                end else if (len_ok_reg) begin
                    cmd.byte_sel = SEL_LEN;
                end else begin
                    cmd.byte_sel = SEL_ZERO;
                end
                if (stat.pos == LastPos) begin
                    cmd.load_work = 1'b1;
                    round_next    = '0;
                    done_next     = len_ok_reg;
                    state_next    = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == 6'(Rounds - 1)) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                cmd.final_add = 1'b1;
                priority if (done_reg) begin
                    emit_next  = '0;
                    state_next = ST_EMIT;
                end else if (fin_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    emit_next    = emit_reg + 3'd1;
                    if (emit_reg == 3'(Words - 1)) begin
                        cmd.clear_msg = 1'b1;
                        fin_next      = 1'b0;
                        len_ok_next   = 1'b0;
                        done_next     = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            round_reg  <= '0;
            emit_reg   <= '0;
            fin_reg    <= 1'b0;
            len_ok_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            round_reg  <= round_next;
            emit_reg   <= emit_next;
            fin_reg    <= fin_next;
            len_ok_reg <= len_ok_next;
            done_reg   <= done_next;
        end
    end

endmodule

// ===== hw/rtl/shabh_dp.sv =====
// Datapath of the SHA-256 byte hasher: block shift register and schedule,
// round logic, chaining words, length counter and output register. Uses shabh_pkg.

module shabh_dp
    import shabh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  shabh_cmd_t  cmd,
    output shabh_stat_t stat,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_word,
    output logic [2:0]  out_index,
    output logic        out_last
);

    // The block enters a byte at a time at the bottom; word t of the schedule
    // window sits at the top once all 64 bytes are in.
    logic [511:0]       sched_reg;
    logic [63:0]        count_reg;
    logic [63:0]        len_reg;
    logic [WordW-1:0]   chain_reg [Words];
    logic [WordW-1:0]   work_reg  [Words];
    logic               out_valid_reg;
    logic [31:0]        out_word_reg;
    logic [2:0]         out_index_reg;
    logic               out_last_reg;

    logic [7:0]  byte_mux;
    logic [31:0] w0, w1, w9, w14, w_new;
    logic [31:0] t1, t2, ch, maj;

    always_comb begin
        unique case (cmd.byte_sel)
            SEL_DATA:  byte_mux = in_byte;
            SEL_PAD80: byte_mux = PadByte;
            SEL_ZERO:  byte_mux = 8'h00;
            SEL_LEN:   byte_mux = len_reg[63:56];
            default:   byte_mux = 8'h00;
        endcase
    end

    assign w0    = sched_reg[511:480];
    assign w1    = sched_reg[479:448];
    assign w9    = sched_reg[223:192];
    assign w14   = sched_reg[63:32];
    assign w_new = small_sig1(w14) + w9 + small_sig0(w1) + w0;

    assign ch  = work_reg[6] ^ (work_reg[4] & (work_reg[5] ^ work_reg[6]));
    assign maj = (work_reg[0] & work_reg[1]) | (work_reg[2] & (work_reg[0] | work_reg[1]));
    assign t1  = work_reg[7] + big_sig1(work_reg[4]) + ch + round_k(cmd.round_idx) + w0;
    assign t2  = big_sig0(work_reg[0]) + maj;

    assign stat.pos      = count_reg[5:0];
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (cmd.shift_en) begin
            sched_reg <= {sched_reg[503:0], byte_mux};
        end else if (cmd.round_en) begin
            sched_reg <= {sched_reg[479:0], w_new};
        end
        if (cmd.latch_len) begin
            len_reg <= {count_reg[60:0], 3'b000};
        end else if (cmd.shift_en && cmd.byte_sel == SEL_LEN) begin
            len_reg <= {len_reg[55:0], 8'h00};
        end
        if (cmd.load_work) begin
            work_reg <= chain_reg;
        end else if (cmd.round_en) begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
        if (cmd.out_load) begin
            out_word_reg  <= chain_reg[cmd.out_idx];
            out_index_reg <= cmd.out_idx;
            out_last_reg  <= (cmd.out_idx == 3'(Words - 1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            chain_reg     <= InitHash;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear_msg) begin
                count_reg <= '0;
            end else if (cmd.shift_en) begin
                count_reg <= count_reg + 64'd1;
            end
            if (cmd.clear_msg) begin
                chain_reg <= InitHash;
            end else if (cmd.final_add) begin
                for (int i = 0; i < Words; i++) begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_index = out_index_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hw/rtl/sha256_byte_hasher.sv =====
// Top level of the streaming SHA-256 byte hasher.
// Instantiates shabh_ctrl and shabh_dp; uses shabh_pkg.
//
// Usage:
//   The slave channel carries one transaction per message byte (s_tuser = 0,
//   byte in s_tdata) or a finish transaction (s_tuser = 1) that ends the message.
//   A finish produces eight master transactions, digest words 0 to 7 with the
//   word index in m_tdata[34:32] and m_tlast on word 7.
//   Ordinary bytes are accepted back to back. The 64th byte of each block
//   starts the compression: the 64 rounds of the single round unit, then an add
//   into the chaining words. s_tready is low while the round unit or padding runs.
//   A finish feeds the padding and length bytes through the same byte path,
//   one per cycle, then one or two compressions, then the eight digest words
//   from one output register, one per cycle while m_tready is high.
//   A stalled receiver holds the current word; the block waits in the output
//   phase and accepts no new byte until word 7 has been loaded.
//   After word 7 the chaining words return to the initial value, ready for
//   the next message. Reset (aresetn low, synchronous) does the same and
//   drops m_tvalid.

module sha256_byte_hasher
    import shabh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
    output logic        m_tlast    // last_word
);

    shabh_cmd_t  cmd;
    shabh_stat_t stat;
    logic [31:0] out_word;
    logic [2:0]  out_index;

    shabh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    shabh_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_byte   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word),
        .out_index (out_index),
        .out_last  (m_tlast)
    );

    assign m_tdata = {5'b00000, out_index, out_word};

    // The last word of a digest always carries index seven.
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[34:32] == 3'd7)
        else $error("digest word flagged last with wrong index");

    // Digest words follow each other without a gap while the receiver takes them.
    a_next_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1)
        else $error("digest word sequence broken");

    // A finish always starts padding or compression, so input stalls next cycle.
    a_finish_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input accepted right after finish");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for sha256_byte_hasher: directed and random messages against a SHA-256 predictor.
// Needs only the RTL of the hasher and its package shabh_pkg.

module tb_top;

    localparam bit KIND_BYTE   = 1'b0;
    localparam bit KIND_FINISH = 1'b1;

    localparam int RANDOM_ITEMS = 360;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 300;
    localparam int SHOW_LIMIT   = 10;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Tracks the hash of the message in flight and holds the digest words still owed.
    class digest_tracker;
        logic [31:0] hash_state [8];
        logic [7:0]  block_bytes [64];
        logic [63:0] msg_len;
        logic [31:0] word_q [$];
        logic [2:0]  index_q [$];
        logic        last_q [$];
        int unsigned error_count;

        function new();
            error_count = 0;
            restart();
        endfunction

        function void restart();
            hash_state = SHA_IV;
            msg_len    = '0;
        endfunction

        function logic [31:0] rotr(input logic [31:0] x, input int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void run_rounds();
            logic [31:0] w [64];
            logic [31:0] a, b, c, d, e, f, g, h;
            logic [31:0] mix0, mix1, sum0, sum1, choose, major, t1, t2;
            for (int i = 0; i < 16; i++)
                w[i] = {block_bytes[4*i], block_bytes[4*i+1],
                        block_bytes[4*i+2], block_bytes[4*i+3]};
            for (int i = 16; i < 64; i++) begin
                mix0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
                mix1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = mix1 + w[i-7] + mix0 + w[i-16];
            end
            {a, b, c, d} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3]};
            {e, f, g, h} = {hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
            for (int i = 0; i < 64; i++) begin
                sum1   = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
                choose = (e & f) ^ (~e & g);
                t1     = h + sum1 + choose + ROUND_CONST[i] + w[i];
                sum0   = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
                major  = (a & b) ^ (a & c) ^ (b & c);
                t2     = sum0 + major;
                h = g;
                g = f;
                f = e;
                e = d + t1;
                d = c;
                c = b;
                b = a;
                a = t1 + t2;
            end
            hash_state[0] += a;
            hash_state[1] += b;
            hash_state[2] += c;
            hash_state[3] += d;
            hash_state[4] += e;
            hash_state[5] += f;
            hash_state[6] += g;
            hash_state[7] += h;
        endfunction

        // Called once per accepted input transaction.
        function void note_input(input bit kind, input logic [7:0] data);
            int pos;
            logic [63:0] bit_len;
            pos = int'(msg_len[5:0]);
            if (kind == KIND_BYTE) begin
                block_bytes[pos] = data;
                msg_len++;
                if (pos == 63)
                    run_rounds();
                return;
            end
            bit_len = msg_len << 3;
            block_bytes[pos] = 8'h80;
            pos++;
            // No room left for the length field: pad out and compress an extra block.
            if (pos > 56) begin
                while (pos < 64) begin
                    block_bytes[pos] = 8'h00;
                    pos++;
                end
                run_rounds();
                pos = 0;
            end
            while (pos < 56) begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++)
                block_bytes[56+i] = bit_len[63-8*i -: 8];
            run_rounds();
            for (int i = 0; i < 8; i++) begin
                word_q.push_back(hash_state[i]);
                index_q.push_back(3'(i));
                last_q.push_back(i == 7);
            end
            restart();
        endfunction

        function void report(input string msg);
            error_count++;
            if (error_count <= SHOW_LIMIT)
                $display("%s", msg);
        endfunction

        function void check_result(input logic [39:0] tdata, input logic tlast);
            logic [31:0] exp_word;
            logic [2:0]  exp_index;
            logic        exp_last;
            if (word_q.size() == 0) begin
                report($sformatf("unexpected digest word %h index %0d last %b",
                                 tdata[31:0], tdata[34:32], tlast));
                return;
            end
            exp_word  = word_q.pop_front();
            exp_index = index_q.pop_front();
            exp_last  = last_q.pop_front();
            if (tdata[31:0] !== exp_word || tdata[34:32] !== exp_index || tlast !== exp_last)
                report($sformatf("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                                 exp_word, exp_index, exp_last,
                                 tdata[31:0], tdata[34:32], tlast));
        endfunction

        function int pending();
            return word_q.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_tuser  = 1'b0;    // [0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;            // [31:0] digest_word, [34:32] word_index, [39:35] zero
    logic        m_tlast;            // last_word

    digest_tracker tracker = new();

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int msg_number    = 0;
    int random_items  = 0;
    int unsigned cycle_count = 0;

    sha256_byte_hasher i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sha256_byte_hasher verification failed");
            $finish;
        end
    end

    // Result side: check each accepted transaction, then decide the next ready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_result(m_tdata, m_tlast);
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_item(input bit kind, input logic [7:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        tracker.note_input(kind, data);
    endtask

    // Each random message runs under one of four idling patterns, in rotation.
    task automatic next_phase();
        case (msg_number % 4)
            0: begin
                src_idle_pct = 0;  sink_stall_pct = 0;
            end
            1: begin
                src_idle_pct = 55; sink_stall_pct = 0;
            end
            2: begin
                src_idle_pct = 0;  sink_stall_pct = 55;
            end
            default: begin
                src_idle_pct = 37; sink_stall_pct = 37;
            end
        endcase
        msg_number++;
    endtask

    task automatic send_random_message(input int len);
        next_phase();
        for (int i = 0; i < len; i++)
            send_item(KIND_BYTE, 8'($urandom_range(255)));
        send_item(KIND_FINISH, 8'($urandom_range(255)));
        random_items += len + 1;
    endtask

    initial begin
        int pick;
        int msg_len;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty messages, one of them straight after another finish.
        send_item(KIND_FINISH, 8'hff);
        send_item(KIND_FINISH, 8'h00);
        // Single bytes at both extremes.
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_BYTE, 8'hff);
        send_item(KIND_FINISH, 8'h5a);
        // The classic three-byte message.
        send_item(KIND_BYTE, 8'h61);
        send_item(KIND_BYTE, 8'h62);
        send_item(KIND_BYTE, 8'h63);
        send_item(KIND_FINISH, 8'hff);
        // A byte equal to the pad marker, and alternating bit patterns.
        send_item(KIND_BYTE, 8'h80);
        send_item(KIND_BYTE, 8'h55);
        send_item(KIND_BYTE, 8'haa);
        send_item(KIND_BYTE, 8'h01);
        send_item(KIND_FINISH, 8'h80);

        // Lengths are short, near the block and padding boundaries, or beyond one block.
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(9);
            if (pick < 5)
                msg_len = $urandom_range(20);
            else if (pick < 9)
                case ($urandom_range(5))
                    0: msg_len = 55;
                    1: msg_len = 56;
                    2: msg_len = 57;
                    3: msg_len = 63;
                    4: msg_len = 64;
                    default: msg_len = 65;
                endcase
            else
                msg_len = $urandom_range(100, 130);
            send_random_message(msg_len);
        end
        s_tvalid <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (tracker.error_count == 0 && tracker.pending() == 0)
            $display("sha256_byte_hasher verification clean");
        else
            $display("sha256_byte_hasher verification failed");
        $finish;
    end

endmodule
